// ===== src/lzsw_pkg.sv =====
// Package for the small-window LZ77 decoder.
// Window and match limits, field widths and the history port struct.
// No dependencies.
package lzsw_pkg;

	localparam int WINDOW_SIZE = 4;
	localparam int MAX_MATCH   = 15;
	localparam int PTR_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

	localparam int DIST_W = 3;
	localparam int LEN_W  = 4;
	localparam int BYTE_W = 8;

	localparam int IN_W  = DIST_W + LEN_W + BYTE_W;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;

	// ring index arithmetic below wraps on PTR_W bits, so WINDOW_SIZE is a power of two
	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic              we;
		ptr_t              wr_ptr;
		logic [BYTE_W-1:0] wr_byte;
		ptr_t              rd_ptr;
	} hist_req_t;

endpackage

// ===== src/lzsw_history.sv =====
// History ring of the small-window LZ77 decoder.
// One write port, one combinational read port; cleared to zeros at reset.
// Depends on lzsw_pkg.
module lzsw_history (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lzsw_pkg::hist_req_t       req,
	output logic [lzsw_pkg::BYTE_W-1:0] rd_byte
);
	import lzsw_pkg::*;

	logic [BYTE_W-1:0] ring_q [WINDOW_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				ring_q[i] <= '0;
			end
		end else if (req.we) begin
			ring_q[req.wr_ptr] <= req.wr_byte;
		end
	end

	assign rd_byte = ring_q[req.rd_ptr];

endmodule

// ===== src/lzsw_seq.sv =====
// Sequencer of the small-window LZ77 decoder.
// Latches a triple, then emits one byte per cycle into a holding register while the output is not stalled.
// Depends on lzsw_pkg.
module lzsw_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lzsw_pkg::DIST_W-1:0] in_dist,
	input  logic [lzsw_pkg::LEN_W-1:0]  in_len,
	input  logic [lzsw_pkg::BYTE_W-1:0] in_lit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lzsw_pkg::BYTE_W-1:0] out_byte,
	output logic                        out_last,
	output lzsw_pkg::hist_req_t         hist_req,
	input  logic [lzsw_pkg::BYTE_W-1:0] hist_byte
);
	import lzsw_pkg::*;

	typedef enum logic {IDLE, RUN} state_t;

	state_t            state_q;
	logic [DIST_W-1:0] dist_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] lit_q;
	ptr_t              wp_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              accept;
	logic              fire;
	logic              copy;
	logic [DIST_W-1:0] dist_sat;
	logic [LEN_W-1:0]  len_sat;
	logic [BYTE_W-1:0] emit_byte;

	assign in_ready = (state_q == IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = (state_q == RUN) && (!out_valid_q || out_ready);
	assign copy     = (cnt_q != len_q);

	always_comb begin
		dist_sat = in_dist;
		if (32'(in_dist) > WINDOW_SIZE) begin
			dist_sat = DIST_W'(WINDOW_SIZE);
		end
		len_sat = in_len;
		if (32'(in_len) > MAX_MATCH) begin
			len_sat = LEN_W'(MAX_MATCH);
		end
		if (in_dist == '0) begin
			len_sat = '0;
		end
	end

	assign emit_byte        = copy ? hist_byte : lit_q;
	assign hist_req.we      = fire;
	assign hist_req.wr_ptr  = wp_q;
	assign hist_req.wr_byte = emit_byte;
	assign hist_req.rd_ptr  = wp_q - ptr_t'(dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= RUN;
						cnt_q   <= '0;
					end
				end
				RUN: begin
					if (fire) begin
						wp_q <= wp_q + ptr_t'(1);
						if (copy) begin
							cnt_q <= cnt_q + LEN_W'(1);
						end else begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
				out_last_q  <= !copy;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_q <= dist_sat;
			len_q  <= len_sat;
			lit_q  <= in_lit;
		end
		if (fire) begin
			out_byte_q <= emit_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== src/lz77_small_window_decoder.sv =====
// Top level of the small-window LZ77 decoder.
// Instantiates lzsw_seq and lzsw_history; depends on lzsw_pkg.
//
// Input stream s_axis: one transaction per triple. tdata fields from bit 0:
// back_distance [2:0], match_length [6:3], literal_byte [14:7], bit 15 zero.
// Output stream m_axis: one transaction per reconstructed byte, tdata[7:0];
// tlast marks the literal that ends a triple.
// A triple gives min(match_length, 15) + 1 bytes, or just the literal when
// back_distance is zero. Distances above 4 are taken as 4. Copies may overlap
// the bytes they produce.
// An accepted triple moves the sequencer to RUN; its first byte is then registered at the output.
// Throughput: one byte per cycle through the sequencer and the four-byte
// history ring while m_axis does not stall; each triple is accepted, then its
// bytes follow one by one. s_axis_tready stays low until its last byte is
// in the output register; the next triple can be accepted while that byte
// still waits.
// Reset clears the history ring to zeros, the write pointer and the output
// valid and last flags. A stall on m_axis_tready holds the output register and pauses the
// sequencer; no byte is lost or repeated.
module lz77_small_window_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [lzsw_pkg::IN_TW-1:0] s_axis_tdata,   // back_distance, match_length, literal_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,   // out_byte
	output logic                       m_axis_tlast
);
	import lzsw_pkg::*;

	hist_req_t         hist_req;
	logic [BYTE_W-1:0] hist_byte;

	lzsw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_dist   (s_axis_tdata[DIST_W-1:0]),
		.in_len    (s_axis_tdata[DIST_W+LEN_W-1:DIST_W]),
		.in_lit    (s_axis_tdata[IN_W-1:DIST_W+LEN_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.hist_req  (hist_req),
		.hist_byte (hist_byte)
	);

	lzsw_history u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hist_req),
		.rd_byte (hist_byte)
	);

endmodule

// ===== src/lzsw_checker.sv =====
// Port-level checks for the small-window LZ77 decoder.
// Bound to lz77_small_window_decoder; uses its handshake and output ports only.
module lzsw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("input accepted again right after a transaction");

	a_no_accept_mid_triple: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("ready while a triple is still being expanded");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("gap in the bytes of one triple");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output changed while stalled");

endmodule

bind lz77_small_window_decoder lzsw_checker u_lzsw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_top.sv =====
// Testbench for lz77_small_window_decoder: triples are driven on s_axis, and
// every byte on m_axis is checked against a history-ring predictor in the bench.
// Depends on lzsw_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;
	import lzsw_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 300;

	typedef struct {
		logic [DIST_W-1:0] bdist;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] lit;
		int                gap_after;
	} triple_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} out_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_TW-1:0] s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;

	triple_t   pending_q[$];
	out_byte_t expected_q[$];
	triple_t   cur_triple;

	logic [BYTE_W-1:0] hist_ring[WINDOW_SIZE];
	int                hist_wr;

	int idle_left = 0;
	int triples_taken = 0;
	int bytes_checked = 0;
	int error_count = 0;
	int rx_gap = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	int rx_cyc = 0;
	int idle_cyc = 0;

	lz77_small_window_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// expands one triple into expected bytes, updating the local history ring
	task automatic expand_triple(input triple_t t);
		int d;
		int n;
		int idx;
		out_byte_t ob;
		d = (t.bdist > WINDOW_SIZE) ? WINDOW_SIZE : int'(t.bdist);
		n = (d == 0) ? 0 : ((t.len > MAX_MATCH) ? MAX_MATCH : int'(t.len));
		for (int k = 0; k < n; k++) begin
			idx = (hist_wr + WINDOW_SIZE - d) % WINDOW_SIZE;
			ob.data = hist_ring[idx];
			ob.last = 1'b0;
			hist_ring[hist_wr] = ob.data;
			hist_wr = (hist_wr + 1) % WINDOW_SIZE;
			expected_q = {expected_q, ob};
		end
		ob.data = t.lit;
		ob.last = 1'b1;
		hist_ring[hist_wr] = t.lit;
		hist_wr = (hist_wr + 1) % WINDOW_SIZE;
		expected_q = {expected_q, ob};
	endtask

	task automatic add_triple(input int bdist, input int len, input int lit, input int gap);
		triple_t t;
		t.bdist = bdist[DIST_W-1:0];
		t.len = len[LEN_W-1:0];
		t.lit = lit[BYTE_W-1:0];
		t.gap_after = gap;
		pending_q = {pending_q, t};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		triple_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			idle_left <= 0;
			for (int i = 0; i < WINDOW_SIZE; i++)
				hist_ring[i] = '0;
			hist_wr = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expand_triple(cur_triple);
				triples_taken <= triples_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (idle_left != 0) begin
					s_tvalid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					cur_triple <= nxt;
					s_tdata <= {1'b0, nxt.lit, nxt.len, nxt.bdist};
					s_tvalid <= 1'b1;
					idle_left <= nxt.gap_after;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold, counted on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && triples_taken >= 40) begin
			hold_cnt <= LONG_HOLD;
			hold_done <= 1'b1;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		out_byte_t exp_b;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (m_tvalid && m_tready) begin
				bytes_checked <= bytes_checked + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
					error_count <= error_count + 1;
				end else begin
					exp_b = expected_q.pop_front();
					if (m_tdata !== exp_b.data || m_tlast !== exp_b.last) begin
						$display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
							$time, exp_b.data, exp_b.last, m_tdata, m_tlast);
						error_count <= error_count + 1;
					end
				end
			end
			if (hold_cnt != 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				m_tready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready && (rx_cyc % 512) >= 128)
					rx_gap <= pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cyc <= 0;
			else
				idle_cyc <= idle_cyc + 1;
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int bdist;
		int len;
		// history still at reset zeros
		add_triple(3, 2, 8'hA5, 0);
		add_triple(1, 0, 8'h01, 0);
		// zero distance drops the length
		add_triple(0, 15, 8'hFF, 1);
		add_triple(0, 0, 8'h00, 0);
		// overlapping copies
		add_triple(1, 15, 8'h3C, 0);
		add_triple(2, 5, 8'h81, 2);
		add_triple(4, 7, 8'h7E, 0);
		// distances past the window clamp to 4, mixed with distances inside it
		add_triple(5, 3, 8'h55, 0);
		add_triple(6, 4, 8'hAA, 0);
		add_triple(7, 15, 8'hFF, 0);
		add_triple(4, 15, 8'h00, 3);
		add_triple(3, 1, 8'hF0, 0);
		add_triple(2, 8, 8'h0F, 0);
		add_triple(1, 1, 8'h80, 0);
		add_triple(7, 0, 8'h01, 0);
		add_triple(2, 2, 8'h7F, 0);
		for (int i = 0; i < 150; i++) begin
			bdist = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
			add_triple(bdist, len, $urandom_range(0, 255),
				(i >= 10 && i < 60) ? 0 : pick_gap());
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d triples and %0d output bytes, with one %0d-cycle output hold",
			triples_taken, bytes_checked, LONG_HOLD);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d errors, %0d bytes still expected", error_count, expected_q.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== lz77_small_window_decoder.f =====
src/lzsw_pkg.sv
src/lzsw_history.sv
src/lzsw_seq.sv
src/lz77_small_window_decoder.sv
src/lzsw_checker.sv
test/tb_top.sv
